### hdl/resonant_lowpass_filter_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the resonant low-pass filter
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef RESONANT_LOWPASS_FILTER_ASSERT_SVH
`define RESONANT_LOWPASS_FILTER_ASSERT_SVH

// Same-cycle implication.
`define RLPF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rlpf same-cycle check failed");

// Next-cycle implication.
`define RLPF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rlpf next-cycle check failed");

`endif

### hdl/rlpf_pkg.sv
// ----------------------------------------------------------------------------
// rlpf_pkg
// Types and fixed constants of the resonant low-pass filter.
// ----------------------------------------------------------------------------
package rlpf_pkg;

  localparam int CUTOFF_W   = 17;  // f, unsigned
  localparam int RESON_W    = 23;  // fb, signed
  localparam int CFG_DATA_W = 23;  // widest register
  localparam int CFG_IDX_W  = 2;

  localparam int STAGE_W = 32;     // stage state width
  localparam int DIFF_W  = 33;     // s1 - s2, also the multiplier data operand
  localparam int TERM_W  = 47;     // clamped bracket term, +/- 2^45
  localparam int T_LO_W  = 23;     // low half of the bracket term
  localparam int COEF_W  = 24;     // multiplier coefficient operand
  localparam int PROD_W  = 64;     // product register
  localparam int WIDE_W  = 64;     // sum width ahead of saturation

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_CUTOFF = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_RESON  = 2'd1;

  localparam logic signed [WIDE_W-1:0] TERM_LIMIT = 64'sd1 <<< 45;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_FB,
    ST_TERM,
    ST_MUL_T,
    ST_MUL_T_HI,
    ST_ADD_S1,
    ST_MUL_S2,
    ST_ADD_S2
  } state_t;

endpackage

### hdl/rlpf_in_if.sv
// ----------------------------------------------------------------------------
// rlpf_in_if
// Input sample channel: valid/ready handshake carrying one audio sample.
// ----------------------------------------------------------------------------
interface rlpf_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

### hdl/rlpf_out_if.sv
// ----------------------------------------------------------------------------
// rlpf_out_if
// Output sample channel: valid/ready handshake carrying one filtered sample.
// ----------------------------------------------------------------------------
interface rlpf_out_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

### hdl/resonant_lowpass_filter.sv
// ----------------------------------------------------------------------------
// resonant_lowpass_filter
// Resonant two-pole low-pass filter, one shared multiplier under a sequencer.
// ----------------------------------------------------------------------------
// Each sample is taken when the filter is idle and then runs through seven
// sequencer steps around one shared signed 33 x 24 multiplier: resonance
// times stage difference, the rounded and clamped bracket term, cutoff times
// the low and then the high half of that term (accumulated in the product
// register), the first stage update, cutoff times the new stage difference,
// and the second stage update. A new sample is accepted only in the idle state,
// after the previous one is done; the last step waits only while an earlier
// result is still held in the output register. Stages are signed 32-bit fixed
// point with FRAC_BITS fraction bits and saturate on every update; the first
// stage resets to zero and the second to one sample unit. Coefficients are
// written through the cfg port; the user must do so only while the filter is
// idle, which the block itself does not enforce. Index 0 is the unsigned
// cutoff f, index 1 the signed resonance fb; other indexes are ignored.
// ----------------------------------------------------------------------------
module resonant_lowpass_filter #(
  parameter int SAMPLE_BITS = 16,
  parameter int FRAC_BITS   = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  rlpf_in_if.sink                             in_ch,
  rlpf_out_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [rlpf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rlpf_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam logic signed [rlpf_pkg::WIDE_W-1:0] ROUND_HALF =
    64'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [rlpf_pkg::STAGE_W-1:0] S2_RESET = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [rlpf_pkg::STAGE_W-1:0] Y_HI =
    (32'sd1 <<< (SAMPLE_BITS - 1)) - 32'sd1;
  localparam logic signed [rlpf_pkg::STAGE_W-1:0] Y_LO = -(32'sd1 <<< (SAMPLE_BITS - 1));
  localparam logic signed [rlpf_pkg::WIDE_W-1:0] S_MAX = 64'sd2147483647;
  localparam logic signed [rlpf_pkg::WIDE_W-1:0] S_MIN = -64'sd2147483648;
  localparam int MUL_W = rlpf_pkg::DIFF_W + rlpf_pkg::COEF_W;

  rlpf_pkg::state_t state_r, state_nxt;

  logic [rlpf_pkg::CUTOFF_W-1:0]               cutoff_r;
  logic signed [rlpf_pkg::RESON_W-1:0]         reson_r;
  logic signed [SAMPLE_BITS-1:0]               x_r, x_nxt;
  logic signed [rlpf_pkg::STAGE_W-1:0]         s1_r, s1_nxt;
  logic signed [rlpf_pkg::STAGE_W-1:0]         s2_r, s2_nxt;
  logic signed [rlpf_pkg::TERM_W-1:0]          t_r, t_nxt;
  logic signed [rlpf_pkg::PROD_W-1:0]          prod_r, prod_nxt;
  logic                                        out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_BITS-1:0]               out_data_r, out_data_nxt;

  logic                                        in_ready;
  logic                                        out_free;
  logic signed [rlpf_pkg::DIFF_W-1:0]          diff;
  logic signed [rlpf_pkg::TERM_W-rlpf_pkg::T_LO_W-1:0] t_hi;
  logic signed [rlpf_pkg::DIFF_W-1:0]          mul_a;
  logic signed [rlpf_pkg::COEF_W-1:0]          mul_b;
  logic signed [MUL_W-1:0]                     mul_p;
  logic signed [rlpf_pkg::WIDE_W-1:0]          rnd;
  logic signed [rlpf_pkg::WIDE_W-1:0]          term;
  logic signed [rlpf_pkg::WIDE_W-1:0]          term_c;
  logic signed [rlpf_pkg::STAGE_W-1:0]         s2_new;
  logic signed [rlpf_pkg::STAGE_W-1:0]         y_int;
  logic signed [rlpf_pkg::STAGE_W-1:0]         y_sat;

  function automatic logic signed [rlpf_pkg::STAGE_W-1:0] sat_stage(
    input logic signed [rlpf_pkg::WIDE_W-1:0] v
  );
    logic signed [rlpf_pkg::WIDE_W-1:0] c;
    begin
      c = v;
      if (v > S_MAX) c = S_MAX;
      if (v < S_MIN) c = S_MIN;
      return c[rlpf_pkg::STAGE_W-1:0];
    end
  endfunction

  assign in_ready      = rst_n && (state_r == rlpf_pkg::ST_IDLE);
  assign out_free      = !out_valid_r || out_ch.ready;
  assign in_ch.ready   = in_ready;
  assign out_ch.valid  = out_valid_r;
  assign out_ch.sample_out = out_data_r;

  // Datapath shared by the sequencer steps
  assign diff  = rlpf_pkg::DIFF_W'(s1_r) - rlpf_pkg::DIFF_W'(s2_r);
  assign t_hi  = t_r[rlpf_pkg::TERM_W-1:rlpf_pkg::T_LO_W];
  assign mul_p = MUL_W'(mul_a) * MUL_W'(mul_b);
  assign rnd   = (prod_r + ROUND_HALF) >>> FRAC_BITS;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      rlpf_pkg::ST_MUL_FB: begin
        mul_a = diff;
        mul_b = rlpf_pkg::COEF_W'(reson_r);
      end
      rlpf_pkg::ST_MUL_T: begin
        mul_a = signed'({{(rlpf_pkg::DIFF_W - rlpf_pkg::T_LO_W){1'b0}},
                         t_r[rlpf_pkg::T_LO_W-1:0]});
        mul_b = signed'({{(rlpf_pkg::COEF_W - rlpf_pkg::CUTOFF_W){1'b0}}, cutoff_r});
      end
      rlpf_pkg::ST_MUL_T_HI: begin
        mul_a = rlpf_pkg::DIFF_W'(t_hi);
        mul_b = signed'({{(rlpf_pkg::COEF_W - rlpf_pkg::CUTOFF_W){1'b0}}, cutoff_r});
      end
      rlpf_pkg::ST_MUL_S2: begin
        mul_a = diff;
        mul_b = signed'({{(rlpf_pkg::COEF_W - rlpf_pkg::CUTOFF_W){1'b0}}, cutoff_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Bracket term: x - s1 + round(fb * d), clamped before the cutoff product
  always_comb begin
    term = (rlpf_pkg::WIDE_W'(x_r) <<< FRAC_BITS) - rlpf_pkg::WIDE_W'(s1_r) + rnd;
    term_c = term;
    if (term > rlpf_pkg::TERM_LIMIT) term_c = rlpf_pkg::TERM_LIMIT;
    if (term < -rlpf_pkg::TERM_LIMIT) term_c = -rlpf_pkg::TERM_LIMIT;
  end

  // Second stage update and its saturated integer part
  always_comb begin
    s2_new = sat_stage(rlpf_pkg::WIDE_W'(s2_r) + rnd);
    y_int  = s2_new >>> FRAC_BITS;
    y_sat  = y_int;
    if (y_int > Y_HI) y_sat = Y_HI;
    if (y_int < Y_LO) y_sat = Y_LO;
  end

  // Sequencer: next state and register updates
  always_comb begin
    state_nxt     = state_r;
    x_nxt         = x_r;
    s1_nxt        = s1_r;
    s2_nxt        = s2_r;
    t_nxt         = t_r;
    prod_nxt      = prod_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    case (state_r)
      rlpf_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          x_nxt     = in_ch.sample_in;
          state_nxt = rlpf_pkg::ST_MUL_FB;
        end
      end
      rlpf_pkg::ST_MUL_FB: begin
        prod_nxt  = rlpf_pkg::PROD_W'(mul_p);
        state_nxt = rlpf_pkg::ST_TERM;
      end
      rlpf_pkg::ST_TERM: begin
        t_nxt     = term_c[rlpf_pkg::TERM_W-1:0];
        state_nxt = rlpf_pkg::ST_MUL_T;
      end
      rlpf_pkg::ST_MUL_T: begin
        // start with the low half of the bracket term
        prod_nxt  = rlpf_pkg::PROD_W'(mul_p);
        state_nxt = rlpf_pkg::ST_MUL_T_HI;
      end
      rlpf_pkg::ST_MUL_T_HI: begin
        // add the high half at its weight
        prod_nxt  = prod_r + (rlpf_pkg::PROD_W'(mul_p) <<< rlpf_pkg::T_LO_W);
        state_nxt = rlpf_pkg::ST_ADD_S1;
      end
      rlpf_pkg::ST_ADD_S1: begin
        s1_nxt    = sat_stage(rlpf_pkg::WIDE_W'(s1_r) + rnd);
        state_nxt = rlpf_pkg::ST_MUL_S2;
      end
      rlpf_pkg::ST_MUL_S2: begin
        prod_nxt  = rlpf_pkg::PROD_W'(mul_p);
        state_nxt = rlpf_pkg::ST_ADD_S2;
      end
      rlpf_pkg::ST_ADD_S2: begin
        // hold until the output register is free
        if (out_free) begin
          s2_nxt        = s2_new;
          out_data_nxt  = y_sat[SAMPLE_BITS-1:0];
          out_valid_nxt = 1'b1;
          state_nxt     = rlpf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rlpf_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rlpf_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r        <= '0;
      s2_r        <= S2_RESET;
      out_valid_r <= 1'b0;
    end else begin
      s1_r        <= s1_nxt;
      s2_r        <= s2_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    t_r        <= t_nxt;
    prod_r     <= prod_nxt;
    out_data_r <= out_data_nxt;
  end

  // Coefficient registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cutoff_r <= '0;
      reson_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        rlpf_pkg::CFG_IDX_CUTOFF: cutoff_r <= cfg_data[rlpf_pkg::CUTOFF_W-1:0];
        rlpf_pkg::CFG_IDX_RESON:  reson_r  <= signed'(cfg_data[rlpf_pkg::RESON_W-1:0]);
        default: ;
      endcase
    end
  end

`include "resonant_lowpass_filter_assert.svh"

  `RLPF_ASSERT_NEXT(a_accept_starts, in_ch.valid && in_ch.ready, state_r == rlpf_pkg::ST_MUL_FB)
  `RLPF_ASSERT_NEXT(a_finish_posts, (state_r == rlpf_pkg::ST_ADD_S2) && out_free, out_valid_r && (state_r == rlpf_pkg::ST_IDLE))
  `RLPF_ASSERT_NOW(a_term_clamped, state_r == rlpf_pkg::ST_MUL_T, (rlpf_pkg::WIDE_W'(t_r) <= rlpf_pkg::TERM_LIMIT) && (rlpf_pkg::WIDE_W'(t_r) >= -rlpf_pkg::TERM_LIMIT))
  `RLPF_ASSERT_NEXT(a_idle_holds_state, state_r == rlpf_pkg::ST_IDLE, $stable(s1_r) && $stable(s2_r))

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Resonant low-pass filter testbench
// Drives audio samples and coefficient writes into the filter and predicts
// every output sample from a fixed-point model of the two cascaded stages.
// Both handshake sides idle at random. The receiver also holds off once for a
// long stretch so that the filter backs up and stalls its input.
// ----------------------------------------------------------------------------
module tb;

  localparam int SAMPLE_W    = 16;
  localparam int FRAC_W      = 16;
  localparam int IDLE_PCT    = 24;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 20;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 68;

  localparam logic [rlpf_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 2'd2;
  localparam logic [rlpf_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 2'd3;

  localparam longint STAGE_MAX = (64'sd1 <<< 31) - 64'sd1;
  localparam longint STAGE_MIN = -(64'sd1 <<< 31);
  localparam longint OUT_MAX   = (64'sd1 <<< (SAMPLE_W - 1)) - 64'sd1;
  localparam longint OUT_MIN   = -(64'sd1 <<< (SAMPLE_W - 1));

  typedef enum int {WAVE_NOISE, WAVE_QUIET, WAVE_SQUARE, WAVE_RAIL} wave_t;

  // Tracks both filter stages and the coefficients, and holds the output
  // samples still owed by the filter.
  class lowpass_tracker;
    logic signed [rlpf_pkg::STAGE_W-1:0]  stage_one;
    logic signed [rlpf_pkg::STAGE_W-1:0]  stage_two;
    logic        [rlpf_pkg::CUTOFF_W-1:0] cutoff;
    logic signed [rlpf_pkg::RESON_W-1:0]  reson;
    logic signed [SAMPLE_W-1:0]           pending_out[$];
    int                                   mismatches;

    function new();
      stage_one  = '0;
      stage_two  = rlpf_pkg::STAGE_W'(1) << FRAC_W;
      cutoff     = '0;
      reson      = '0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [rlpf_pkg::CFG_IDX_W-1:0] idx,
                            logic [rlpf_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        rlpf_pkg::CFG_IDX_CUTOFF: cutoff = data[rlpf_pkg::CUTOFF_W-1:0];
        rlpf_pkg::CFG_IDX_RESON:  reson  = data[rlpf_pkg::RESON_W-1:0];
        default: ;
      endcase
    endfunction

    // round to nearest, ties toward plus infinity
    function longint scale_round(longint p);
      return (p + (64'sd1 <<< (FRAC_W - 1))) >>> FRAC_W;
    endfunction

    function logic signed [rlpf_pkg::STAGE_W-1:0] sat_stage(longint v);
      if (v > STAGE_MAX) return rlpf_pkg::STAGE_W'(STAGE_MAX);
      if (v < STAGE_MIN) return rlpf_pkg::STAGE_W'(STAGE_MIN);
      return rlpf_pkg::STAGE_W'(v);
    endfunction

    function void note_sample(logic signed [SAMPLE_W-1:0] x);
      longint xs;
      longint fb_term;
      longint bracket;
      longint y;
      xs      = longint'(x) <<< FRAC_W;
      fb_term = scale_round(longint'(reson) * (longint'(stage_one) - longint'(stage_two)));
      bracket = xs - longint'(stage_one) + fb_term;
      if (bracket > rlpf_pkg::TERM_LIMIT) bracket = rlpf_pkg::TERM_LIMIT;
      if (bracket < -rlpf_pkg::TERM_LIMIT) bracket = -rlpf_pkg::TERM_LIMIT;
      stage_one = sat_stage(longint'(stage_one) + scale_round(longint'(cutoff) * bracket));
      stage_two = sat_stage(longint'(stage_two) +
                            scale_round(longint'(cutoff) *
                                        (longint'(stage_one) - longint'(stage_two))));
      y = longint'(stage_two) >>> FRAC_W;
      if (y > OUT_MAX) y = OUT_MAX;
      if (y < OUT_MIN) y = OUT_MIN;
      pending_out.push_back(SAMPLE_W'(y));
    endfunction

    function void check_output(logic signed [SAMPLE_W-1:0] got);
      logic signed [SAMPLE_W-1:0] want;
      if (pending_out.size() == 0) begin
        $error("sample_out: no transaction expected, actual %0d", got);
        mismatches++;
      end else begin
        want = pending_out.pop_front();
        if (got !== want) begin
          $error("sample_out mismatch: expected %0d, actual %0d", want, got);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [rlpf_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [rlpf_pkg::CFG_DATA_W-1:0] cfg_data;

  rlpf_in_if  #(.SAMPLE_BITS(SAMPLE_W)) in_bus();
  rlpf_out_if #(.SAMPLE_BITS(SAMPLE_W)) out_bus();

  resonant_lowpass_filter #(
    .SAMPLE_BITS(SAMPLE_W),
    .FRAC_BITS  (FRAC_W)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_bus),
    .out_ch   (out_bus),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  lowpass_tracker sb = new();
  bit  steady;         // no idling on either side
  bit  offering;       // in_bus.valid is currently high
  int  hold_request;   // long receiver hold-off, picked up by the receiver

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver: check each output transaction, then pick ready for next cycle.
  initial begin
    int hold_left;
    hold_left = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_bus.valid && out_bus.ready) sb.check_output(out_bus.sample_out);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (!rst_n) begin
        out_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  initial begin
    #400000;
    $display("simulation failed");
    $finish;
  end

  // Leave valid high; the caller lowers it only when a gap follows.
  task automatic send_sample(logic signed [SAMPLE_W-1:0] x);
    in_bus.valid     <= 1'b1;
    in_bus.sample_in <= x;
    offering = 1'b1;
    do @(posedge clk); while (!in_bus.ready);
    sb.note_sample(x);
  endtask

  task automatic stop_offer();
    if (offering) begin
      in_bus.valid <= 1'b0;
      offering = 1'b0;
    end
  endtask

  task automatic idle_gap(int cycles);
    stop_offer();
    repeat (cycles) @(posedge clk);
  endtask

  // Hold the sender until every owed sample has come back, then let the
  // sequencer settle before touching the coefficients.
  task automatic drain_filter();
    stop_offer();
    while (sb.pending_out.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic load_coefs(logic [rlpf_pkg::CUTOFF_W-1:0] f,
                            logic [rlpf_pkg::RESON_W-1:0] fb);
    logic [rlpf_pkg::CFG_DATA_W-rlpf_pkg::CUTOFF_W-1:0] junk;
    logic [rlpf_pkg::CFG_DATA_W-1:0] f_word;
    logic [rlpf_pkg::CFG_DATA_W-1:0] spare_word;
    logic [rlpf_pkg::CFG_IDX_W-1:0]  spare_idx;
    junk       = (rlpf_pkg::CFG_DATA_W - rlpf_pkg::CUTOFF_W)'($urandom);
    f_word     = {junk, f};   // bits above the cutoff width must be dropped
    spare_word = rlpf_pkg::CFG_DATA_W'($urandom);
    spare_idx  = $urandom_range(1) ? CFG_IDX_SPARE_HI : CFG_IDX_SPARE_LO;
    cfg_we    <= 1'b1;
    cfg_index <= rlpf_pkg::CFG_IDX_CUTOFF;
    cfg_data  <= f_word;
    @(posedge clk);
    sb.write_reg(rlpf_pkg::CFG_IDX_CUTOFF, f_word);
    cfg_index <= rlpf_pkg::CFG_IDX_RESON;
    cfg_data  <= fb;
    @(posedge clk);
    sb.write_reg(rlpf_pkg::CFG_IDX_RESON, fb);
    cfg_index <= spare_idx;
    cfg_data  <= spare_word;
    @(posedge clk);
    sb.write_reg(spare_idx, spare_word);
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample(wave_t kind, int n,
                                                             int period, int amp);
    case (kind)
      WAVE_NOISE:  return SAMPLE_W'($urandom);
      WAVE_QUIET:  return SAMPLE_W'(int'($urandom_range(512)) - 256);
      WAVE_SQUARE: return SAMPLE_W'(((n / period) % 2 == 0) ? amp : -amp);
      default:     return $urandom_range(1) ? SAMPLE_W'(OUT_MAX) : SAMPLE_W'(OUT_MIN);
    endcase
  endfunction

  initial begin
    logic signed [SAMPLE_W-1:0] corner_samples[10];
    logic [rlpf_pkg::CUTOFF_W-1:0] f;
    logic [rlpf_pkg::RESON_W-1:0]  fb;
    wave_t kind;
    int period;
    int amp;

    corner_samples = '{
      16'sh7fff, 16'sh7fff, -16'sh8000, -16'sh8000, 16'sh0000,
      -16'sh0001, 16'sh0001, 16'sh5555, -16'sh5556, 16'sh0000
    };
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    in_bus.valid     = 1'b0;
    in_bus.sample_in = '0;
    steady           = 1'b0;
    offering         = 1'b0;
    hold_request     = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset coefficients: output must sit at the second stage's reset value
    send_sample(16'sh7fff);
    send_sample(-16'sh8000);
    drain_filter();

    load_coefs(17'h08000, 23'h020000);
    foreach (corner_samples[i]) send_sample(corner_samples[i]);
    drain_filter();

    // widest cutoff with strongest feedback of either sign drives saturation
    load_coefs(17'h1ffff, 23'h3fffff);
    for (int i = 0; i < 5; i++) send_sample((i % 2 == 0) ? 16'sh7fff : -16'sh8000);
    drain_filter();
    load_coefs(17'h1ffff, 23'h400000);
    for (int i = 0; i < 5; i++) send_sample((i % 2 == 0) ? -16'sh8000 : 16'sh7fff);
    drain_filter();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin f = 17'h1ffff; fb = 23'h3fffff; end
        1: begin f = 17'h00000; fb = 23'h400000; end
        2: begin f = 17'h00001; fb = 23'h000000; end
        3: begin f = 17'h10000; fb = 23'h010000; end
        default: begin
          case ($urandom_range(2))
            0: f = rlpf_pkg::CUTOFF_W'($urandom_range(8192));
            1: f = rlpf_pkg::CUTOFF_W'($urandom);
            default: f = rlpf_pkg::CUTOFF_W'($urandom_range(131071, 98304));
          endcase
          fb = $urandom_range(1) ? rlpf_pkg::RESON_W'($urandom_range(4 * 65536)) :
                                   rlpf_pkg::RESON_W'($urandom);
        end
      endcase
      load_coefs(f, fb);
      steady = (p == 3);
      if (p == 5) hold_request = HOLD_CYCLES;
      kind   = wave_t'($urandom_range(3));
      period = $urandom_range(40, 2);
      amp    = $urandom_range(32767);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (!steady && $urandom_range(99) < IDLE_PCT) idle_gap($urandom_range(12, 1));
        // switch waveform now and then so a phase mixes settled and noisy input
        if ($urandom_range(99) < 5) kind = wave_t'($urandom_range(3));
        send_sample(pick_sample(kind, n, period, amp));
      end
      drain_filter();
      steady = 1'b0;
    end

    stop_offer();
    while (sb.pending_out.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_out.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
